/* src/fwra_pkg.sv */
// Shared operation codes and types for the queue with running average.
`default_nettype none

package fwra_pkg;

   // Request operation codes
   localparam int OP_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

endpackage : fwra_pkg

`default_nettype wire

/* src/fifo_with_running_average_core.sv */
// Ring-buffer queue of signed samples with running sum and bit-serial mean divider.
// A request runs through the LOAD, PREP, DIV and FINISH states; FINISH registers the result strobe.
// Requests do not overlap: the next is taken only back in idle, as the result strobe ends.
//   The DIV state steps the restoring divider, which produces one quotient bit per cycle.
// Reset: synchronous, active high. It empties the queue and zeroes the pointers and the sum.
//   Store contents are not cleared. The receiver cannot stall: each result shows for one cycle.
`default_nettype none

module fifo_with_running_average_core
   import fwra_pkg::*;
#(
   parameter int DEPTH        = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                start,
   output logic                               busy,
   input  wire         [OP_W-1:0]             req_operation,
   input  wire  signed [SAMPLE_WIDTH-1:0]     req_sample_in,
   // result channel
   output logic                               rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_front_value,
   output logic                               rsp_is_empty,
   output logic        [$clog2(DEPTH+1)-1:0]  rsp_entry_count,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_mean_value,
   output logic                               rsp_op_error
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH+1);
   localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } state_type;

   // sequencer and queue state
   state_type                 state_ff;
   op_type                    op_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      err_ff, err_in;

   // divider registers
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [SUM_W-1:0]          quo_ff, quo_in;
   logic                      neg_ff;
   logic [STEP_W-1:0]         step_ff;

   // ring store and its registered read port
   logic signed [SAMPLE_WIDTH-1:0] ring_mem [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] mem_rd_ff;
   logic                      mem_we;

   // result registers
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] front_ff;
   logic                      empty_ff;
   logic [CNT_W-1:0]          cnt_out_ff;
   logic signed [SAMPLE_WIDTH-1:0] mean_ff;
   logic                      err_out_ff;

   logic                      is_full;
   logic                      is_none;
   logic [CNT_W:0]            trial;
   logic                      trial_ge;
   logic [SUM_W-1:0]          sum_mag;
   logic [SUM_W-1:0]          quo_signed;

   assign is_full = (count_ff == CNT_W'(DEPTH));
   assign is_none = (count_ff == '0);
   assign mem_we  = (state_ff == ST_LOAD) && (op_ff == OP_PUSH) && !is_full;

   // Apply the queued operation to pointers, count and sum
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      err_in    = 1'b0;
      unique case (op_ff)
         OP_PUSH: begin
            if (is_full) begin
               err_in = 1'b1;
            end else begin
               wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
               count_in  = count_ff + 1'b1;
               sum_in    = sum_ff + {{(SUM_W-SAMPLE_WIDTH){sample_ff[SAMPLE_WIDTH-1]}},
                                     sample_ff};
            end
         end
         OP_POP: begin
            if (is_none) begin
               err_in = 1'b1;
            end else begin
               rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
               count_in  = count_ff - 1'b1;
               sum_in    = sum_ff - {{(SUM_W-SAMPLE_WIDTH){mem_rd_ff[SAMPLE_WIDTH-1]}},
                                     mem_rd_ff};
            end
         end
         OP_QUERY: begin
         end
         OP_CLEAR: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            count_in  = '0;
            sum_in    = '0;
         end
         default: begin
         end
      endcase
   end

   // One restoring division step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      trial_ge = (trial >= {1'b0, count_ff});
      rem_in   = trial_ge ? CNT_W'(trial - {1'b0, count_ff}) : CNT_W'(trial);
      quo_in   = {quo_ff[SUM_W-2:0], trial_ge};
   end

   assign sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign quo_signed = neg_ff ? SUM_W'(-quo_ff) : quo_ff;

   // Write at the write pointer, read the front every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_ptr_ff] <= sample_ff;
      end
      mem_rd_ff <= ring_mem[rd_ptr_ff];
   end

   // Sequencer, queue state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff     <= op_type'(req_operation);
                  sample_ff <= req_sample_in;
                  state_ff  <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               rd_ptr_ff <= rd_ptr_in;
               wr_ptr_ff <= wr_ptr_in;
               count_ff  <= count_in;
               sum_ff    <= sum_in;
               err_ff    <= err_in;
               state_ff  <= ST_PREP;
            end
            ST_PREP: begin
               // load the dividend magnitude and remember its sign
               quo_ff   <= sum_mag;
               neg_ff   <= sum_ff[SUM_W-1];
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SUM_W-1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // present the result for one cycle
               rsp_valid_ff <= 1'b1;
               front_ff     <= is_none ? '0 : mem_rd_ff;
               mean_ff      <= is_none ? '0 : SAMPLE_WIDTH'(quo_signed);
               empty_ff     <= is_none;
               cnt_out_ff   <= count_ff;
               err_out_ff   <= err_ff;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_mean_value  = mean_ff;
   assign rsp_op_error    = err_out_ff;

endmodule : fifo_with_running_average_core

`default_nettype wire
